// ===== rtl/ilru_pkg.sv =====
// Shared constants, codes and types of the idle LRU eviction policy unit.
package ilru_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Field widths
   localparam int OP_W          = 2;
   localparam int ENTRY_INDEX_W = 4;
   localparam int TIME_W        = 32;
   localparam int TIMEOUT_W     = 16;
   localparam int MAX_RES_W     = 5;
   localparam int EV_CNT_W      = 5;
   localparam int CMP_W         = (IDX_W > ENTRY_INDEX_W) ? IDX_W : ENTRY_INDEX_W;

   // Eviction cap per request
   localparam int MAX_EVICTIONS = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RESIDENT = 1'd1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 16'd120;
   localparam logic [MAX_RES_W-1:0] MAX_RES_RESET    = 5'd3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK    = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH    = 2'd2;

   // Result kinds
   localparam logic KIND_NOTICE = 1'b0;
   localparam logic KIND_DONE   = 1'b1;

   // Result of the shared age unit
   typedef struct packed {
      logic [TIME_W-1:0] age;
      logic              timed_out;
      logic              older;
   } ilru_age_type;

endpackage

// ===== rtl/ilru_req_if.sv =====
// Request channel of the idle LRU eviction policy unit.
interface ilru_req_if;
   import ilru_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [ENTRY_INDEX_W-1:0] entry_index;
   logic [TIME_W-1:0]        now_seconds;

   modport source (output valid, op, entry_index, now_seconds, input ready);
   modport sink   (input valid, op, entry_index, now_seconds, output ready);
endinterface

// ===== rtl/ilru_rsp_if.sv =====
// Response channel of the idle LRU eviction policy unit.
interface ilru_rsp_if;
   import ilru_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [ENTRY_INDEX_W-1:0] evicted_index;
   logic [EV_CNT_W-1:0]      evicted_count;
   logic                     last;

   modport source (output valid, kind, evicted_index, evicted_count, last, input ready);
   modport sink   (input valid, kind, evicted_index, evicted_count, last, output ready);
endinterface

// ===== rtl/idle_lru_eviction_policy_unit.sv =====
// Idle LRU eviction policy unit: sequencer, resident bits and response register.
// Activate or unknown op: the done state registers the completion; ready returns with it.
// Flush: a read and an evaluate state per entry, a notice state per notice, then the done state.
// Check: a resident count over all entries, a mode state, then the scan; with excess, each
// eviction takes a full scan plus a pick state. Response stalls hold the notice, pick and done states.
// Reset clears resident bits and loads timeout 120 and limit 3; stamps stay uncleared.
module idle_lru_eviction_policy_unit (
   input  logic                            clock,
   input  logic                            reset,
   ilru_req_if.sink                        req_chan,
   ilru_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [ilru_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ilru_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ilru_pkg::*;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_COUNT = 3'd1;
   localparam logic [2:0] S_MODE  = 3'd2;
   localparam logic [2:0] S_RD    = 3'd3;
   localparam logic [2:0] S_EV    = 3'd4;
   localparam logic [2:0] S_NOTE  = 3'd5;
   localparam logic [2:0] S_PICK  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

   logic [2:0]               state_ff, state_in;
   logic [TIMEOUT_W-1:0]     timeout_ff, timeout_in;
   logic [MAX_RES_W-1:0]     max_res_ff, max_res_in;
   logic [TABLE_ENTRIES-1:0] resident_ff, resident_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [ENTRY_INDEX_W-1:0] act_ff, act_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         excess_ff, excess_in;
   logic                     excess_mode_ff, excess_mode_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         best_ff, best_in;
   logic [TIME_W-1:0]        best_age_ff, best_age_in;
   logic [EV_CNT_W-1:0]      nev_ff, nev_in;

   logic                     out_valid_ff, out_valid_in;
   logic                     out_kind_ff, out_kind_in;
   logic [ENTRY_INDEX_W-1:0] out_index_ff, out_index_in;
   logic [EV_CNT_W-1:0]      out_count_ff, out_count_in;
   logic                     out_last_ff, out_last_in;

   logic                     req_accept;
   logic                     out_free;
   logic                     ram_we;
   logic [TIME_W-1:0]        stamp;
   ilru_age_type             age_res;
   logic                     not_active;
   logic                     cand;
   logic                     below_cap;
   logic [EV_CNT_W-1:0]      nev_inc;

   // Stamp memory and shared age unit
   ilru_stamp_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(req_chan.entry_index)),
      .wr_data (req_chan.now_seconds),
      .rd_addr (scan_ff),
      .rd_data (stamp)
   );

   ilru_age_unit u_age (
      .now_seconds (now_ff),
      .stamp       (stamp),
      .timeout     (timeout_ff),
      .best_age    (best_age_ff),
      .result      (age_res)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign ram_we         = req_accept && (req_chan.op == OP_ACTIVATE)
                           && (32'(req_chan.entry_index) < TABLE_ENTRIES);

   // Candidate test for the entry under scan
   assign not_active = (CMP_W'(scan_ff) != CMP_W'(act_ff));
   assign below_cap  = (32'(nev_ff) < MAX_EVICTIONS);
   assign nev_inc    = nev_ff + EV_CNT_W'(1);
   always_comb begin
      if (op_ff == OP_FLUSH) begin
         cand = resident_ff[scan_ff] && not_active;
      end else begin
         cand = resident_ff[scan_ff] && not_active && age_res.timed_out;
      end
   end

   // Next state and datapath
   always_comb begin
      state_in       = state_ff;
      timeout_in     = timeout_ff;
      max_res_in     = max_res_ff;
      resident_in    = resident_ff;
      op_in          = op_ff;
      act_in         = act_ff;
      now_in         = now_ff;
      scan_in        = scan_ff;
      cnt_in         = cnt_ff;
      excess_in      = excess_ff;
      excess_mode_in = excess_mode_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_age_in    = best_age_ff;
      nev_in         = nev_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_kind_in    = out_kind_ff;
      out_index_in   = out_index_ff;
      out_count_in   = out_count_ff;
      out_last_in    = out_last_ff;

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            REG_IDLE_TIMEOUT: timeout_in = TIMEOUT_W'(csr_wdata);
            REG_MAX_RESIDENT: max_res_in = MAX_RES_W'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in          = req_chan.op;
               act_in         = req_chan.entry_index;
               now_in         = req_chan.now_seconds;
               scan_in        = '0;
               cnt_in         = '0;
               nev_in         = '0;
               found_in       = 1'b0;
               best_age_in    = '0;
               excess_mode_in = 1'b0;
               case (req_chan.op)
                  OP_ACTIVATE: begin
                     if (ram_we) begin
                        resident_in[IDX_W'(req_chan.entry_index)] = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  OP_CHECK: state_in = S_COUNT;
                  OP_FLUSH: state_in = S_RD;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_COUNT: begin
            cnt_in = cnt_ff + CNT_W'(resident_ff[scan_ff]);
            if (scan_ff == LAST_SLOT) begin
               scan_in  = '0;
               state_in = S_MODE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         S_MODE: begin
            excess_mode_in = (32'(cnt_ff) > 32'(max_res_ff));
            excess_in      = CNT_W'(32'(cnt_ff) - 32'(max_res_ff));
            state_in       = S_RD;
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (excess_mode_ff) begin
               // Track oldest idle entry, lower index wins ties
               if (cand && (!found_ff || age_res.older)) begin
                  found_in    = 1'b1;
                  best_in     = scan_ff;
                  best_age_in = age_res.age;
               end
               if (scan_ff == LAST_SLOT) begin
                  state_in = S_PICK;
               end else begin
                  scan_in  = scan_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end else if (cand && below_cap) begin
               state_in = S_NOTE;
            end else if (scan_ff == LAST_SLOT) begin
               state_in = S_DONE;
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = S_RD;
            end
         end
         S_NOTE: begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_kind_in           = KIND_NOTICE;
               out_index_in          = ENTRY_INDEX_W'(scan_ff);
               out_count_in          = '0;
               out_last_in           = 1'b0;
               resident_in[scan_ff]  = 1'b0;
               nev_in                = nev_inc;
               if (scan_ff == LAST_SLOT) begin
                  state_in = S_DONE;
               end else begin
                  scan_in  = scan_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_PICK: begin
            if (!found_ff) begin
               state_in = S_DONE;
            end else if (out_free) begin
               out_valid_in          = 1'b1;
               out_kind_in           = KIND_NOTICE;
               out_index_in          = ENTRY_INDEX_W'(best_ff);
               out_count_in          = '0;
               out_last_in           = 1'b0;
               resident_in[best_ff]  = 1'b0;
               nev_in                = nev_inc;
               found_in              = 1'b0;
               best_age_in           = '0;
               scan_in               = '0;
               if ((32'(nev_inc) >= 32'(excess_ff)) || (32'(nev_inc) >= MAX_EVICTIONS)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_DONE;
               out_index_in = '0;
               out_count_in = nev_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         max_res_ff   <= MAX_RES_RESET;
         resident_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         max_res_ff   <= max_res_in;
         resident_ff  <= resident_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      act_ff         <= act_in;
      now_ff         <= now_in;
      scan_ff        <= scan_in;
      cnt_ff         <= cnt_in;
      excess_ff      <= excess_in;
      excess_mode_ff <= excess_mode_in;
      found_ff       <= found_in;
      best_ff        <= best_in;
      best_age_ff    <= best_age_in;
      nev_ff         <= nev_in;
      out_kind_ff    <= out_kind_in;
      out_index_ff   <= out_index_in;
      out_count_ff   <= out_count_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.evicted_index = out_index_ff;
   assign rsp_chan.evicted_count = out_count_ff;
   assign rsp_chan.last          = out_last_ff;

   // A request is taken only once, the block is busy right after it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_chan.ready)
      else $error("request accepted while busy");

   // Completion always closes the request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.kind == rsp_chan.last))
      else $error("completion and last flag disagree");

   // A notice clears the resident bit of the entry it reports
   a_notice_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NOTE && out_free) |=> !resident_ff[$past(scan_ff)])
      else $error("evicted entry still resident");

   // Eviction count never passes the cap
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (32'(nev_ff) <= MAX_EVICTIONS))
      else $error("eviction count beyond cap");
endmodule

// ===== rtl/ilru_stamp_ram.sv =====
// Last-active time stamp memory, one write port and one registered read port.
module ilru_stamp_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ilru_pkg::IDX_W-1:0]  wr_addr,
   input  logic [ilru_pkg::TIME_W-1:0] wr_data,
   input  logic [ilru_pkg::IDX_W-1:0]  rd_addr,
   output logic [ilru_pkg::TIME_W-1:0] rd_data
);
   import ilru_pkg::*;

   logic [TIME_W-1:0] mem [TABLE_ENTRIES];
   logic [TIME_W-1:0] rd_data_ff;

   // Write stamp
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read stamp
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/ilru_age_unit.sv =====
// Shared age unit: wrapping age, timeout compare and oldest-so-far compare.
module ilru_age_unit (
   input  logic [ilru_pkg::TIME_W-1:0]    now_seconds,
   input  logic [ilru_pkg::TIME_W-1:0]    stamp,
   input  logic [ilru_pkg::TIMEOUT_W-1:0] timeout,
   input  logic [ilru_pkg::TIME_W-1:0]    best_age,
   output ilru_pkg::ilru_age_type         result
);
   import ilru_pkg::*;

   logic [TIME_W-1:0] age;

   // Age modulo 2^32
   assign age = now_seconds - stamp;

   assign result.age       = age;
   assign result.timed_out = (age >= TIME_W'(timeout));
   assign result.older     = (age > best_age);
endmodule
